// ----- hdl/wcts_pkg.sv -----
// Shared types and constants for the wall column texture stepper.
package wcts_pkg;

  localparam int TEX_H_W   = 13;   // texture_height register width
  localparam int COL_W     = 10;   // screen column width
  localparam int STRIP_W   = 16;   // strip height width
  localparam int TEX_W     = 12;   // texture coordinate width
  localparam int ROW_OUT_W = 9;    // screen row width on the result
  localparam int OFF_W     = 15;   // start offset (rows above the screen) width
  localparam int POS_W     = 32;   // fixed-point position and step width

  localparam logic [TEX_H_W-1:0] TEX_H_MAX   = 13'd4096;
  localparam logic [TEX_H_W-1:0] TEX_H_RESET = 13'd64;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ROW   = 1'b1;

  // Control from the sequencer to the shared arithmetic unit.
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_step;
  } wcts_ctl_t;

endpackage

// ----- hdl/wcts_if.sv -----
// Valid/ready channel interfaces for strip items and pixel results.
interface wcts_item_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [wcts_pkg::COL_W-1:0]    column;
  logic [wcts_pkg::STRIP_W-1:0]  strip_height;
  logic [wcts_pkg::TEX_W-1:0]    tex_column;

  modport source (output valid, mode, column, strip_height, tex_column, input ready);
  modport sink   (input valid, mode, column, strip_height, tex_column, output ready);
endinterface

interface wcts_pixel_if;
  logic                            valid;
  logic                            ready;
  logic                            pixel_valid;
  logic [wcts_pkg::COL_W-1:0]      out_column;
  logic [wcts_pkg::ROW_OUT_W-1:0]  out_row;
  logic [wcts_pkg::TEX_W-1:0]      out_tex_x;
  logic [wcts_pkg::TEX_W-1:0]      out_tex_y;
  logic                            last_row;

  modport source (output valid, pixel_valid, out_column, out_row, out_tex_x, out_tex_y,
                  last_row, input ready);
  modport sink   (input valid, pixel_valid, out_column, out_row, out_tex_x, out_tex_y,
                  last_row, output ready);
endinterface

// ----- hdl/wcts_arith.sv -----
// Shared-adder arithmetic unit: serial restoring divide, then shift-add multiply.
module wcts_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  wcts_pkg::wcts_ctl_t           ctl,
  input  logic [wcts_pkg::TEX_H_W-1:0]  tex_height,
  input  logic [wcts_pkg::STRIP_W-1:0]  divisor_in,
  input  logic [wcts_pkg::OFF_W-1:0]    offset_in,
  output logic [wcts_pkg::POS_W-1:0]    step,
  output logic [wcts_pkg::POS_W-1:0]    product
);
  import wcts_pkg::*;

  localparam int DW = TEX_H_W + FRAC_BITS;   // dividend and quotient width
  localparam int PW = OFF_W + POS_W;         // full product width
  localparam int AW = PW + 1;                // adder width, top bit is the sign
  localparam int QX = DW + POS_W + 1;        // quotient extended for saturation

  logic [STRIP_W-1:0] divisor;
  logic [STRIP_W-1:0] rem;
  logic [DW-1:0]      dvd;
  logic [OFF_W-1:0]   mplier;
  logic [PW-1:0]      prod;

  logic [STRIP_W:0]   trial;
  logic [AW-1:0]      add_a;
  logic [AW-1:0]      add_b;
  logic               add_cin;
  logic [AW-1:0]      add_sum;
  logic               q_bit;
  logic [QX-1:0]      q_ext;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem, dvd[DW-1]};
    if (ctl.mul_step) begin
      add_a   = AW'({prod[PW-2:0], 1'b0});
      add_b   = mplier[OFF_W-1] ? AW'(step) : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = AW'(trial);
      add_b   = ~(AW'(divisor));
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + AW'(add_cin);
    q_bit   = !add_sum[AW-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      divisor <= divisor_in;
      rem     <= '0;
      dvd     <= {tex_height, {FRAC_BITS{1'b0}}};
      mplier  <= offset_in;
      prod    <= '0;
    end else if (ctl.div_step) begin
      rem <= q_bit ? add_sum[STRIP_W-1:0] : trial[STRIP_W-1:0];
      dvd <= {dvd[DW-2:0], q_bit};
    end else if (ctl.mul_step) begin
      prod   <= add_sum[PW-1:0];
      mplier <= {mplier[OFF_W-2:0], 1'b0};
    end
  end

  always_comb begin
    q_ext   = QX'(dvd);
    step    = (|q_ext[QX-1:POS_W]) ? '1 : q_ext[POS_W-1:0];
    product = (|prod[PW-1:POS_W]) ? '1 : prod[POS_W-1:0];
  end

endmodule

// ----- hdl/wall_column_texture_stepper.sv -----
// Top level of the wall column texture stepper.
//
// This block walks one vertical wall strip of a raycaster and produces a
// texture address for every screen row of it. A start transaction (mode 0)
// latches the column, the texture column and the strip height; it computes
// the fixed-point step texture_height / strip_height, the top and bottom
// rows centered on the screen, and, for a strip taller than the screen, the
// texture offset of the first visible row. Each row transaction (mode 1)
// returns the pixel at the current row and moves down one row; the bottom
// row is flagged with last_row and ends the strip. Every input transaction
// returns exactly one result transaction; a start, or a row with no active
// strip, returns an all-zero result with pixel_valid low. A strip streams
// at one pixel per clock while the result channel keeps up. A start
// transaction occupies the block while the step comes from a serial
// restoring divider that makes one quotient bit a cycle and, when the strip
// is taller than the screen, the start offset from a shift-add multiplier
// taking one offset bit a cycle, both built around a single shared adder.
// Its all-zero result is delivered at once, while the divide runs.
// The texture_height register is written through cfg_write/cfg_data and
// must only change while the block is idle.
module wall_column_texture_stepper #(
  parameter int SCREEN_HEIGHT  = 512,
  parameter int SCREEN_COLUMNS = 1024,
  parameter int FRAC_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [wcts_pkg::TEX_H_W-1:0]  cfg_data,
  wcts_item_if.sink                     item,
  wcts_pixel_if.source                  result
);
  import wcts_pkg::*;

  localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
  localparam int DIV_CYCLES = TEX_H_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);
  localparam int SW1        = STRIP_W + 1;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(OFF_W - 1);
  localparam logic [SW1-1:0]   HALF_H   = SW1'(SCREEN_HEIGHT / 2);
  localparam logic [SW1-1:0]   FULL_H   = SW1'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [11:0]      COL_MAX  = 12'(SCREEN_COLUMNS - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [TEX_H_W-1:0] texture_height;
  logic [POS_W-1:0]   tex_position;
  logic [POS_W-1:0]   tex_step;
  logic [ROW_W-1:0]   current_row;
  logic [ROW_W-1:0]   bottom_row;
  logic               span_active;
  logic [COL_W-1:0]   strip_column;
  logic [TEX_W-1:0]   strip_tex_x;
  logic               use_offset;

  logic               res_valid;
  logic               res_pixel_valid;
  logic [COL_W-1:0]   res_column;
  logic [ROW_OUT_W-1:0] res_row;
  logic [TEX_W-1:0]   res_tex_x;
  logic [TEX_W-1:0]   res_tex_y;
  logic               res_last;

  wcts_ctl_t          ctl;
  logic [POS_W-1:0]   div_step_val;
  logic [POS_W-1:0]   mul_product;

  logic               accept, start_acc, row_acc, row_hit;
  logic [TEX_H_W-1:0] h_eff;
  logic [STRIP_W-1:0] s_eff;
  logic [SW1-1:0]     s_half;
  logic [SW1-1:0]     top_wide, bot_wide, off_wide;
  logic [ROW_W-1:0]   top_row, bot_row;
  logic               taller;
  logic [OFF_W-1:0]   offset;
  logic [COL_W-1:0]   col_sat;
  logic [POS_W-1:0]   ty_wide;
  logic [TEX_W-1:0]   tex_y;
  logic               is_last;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos_next;

  // The block takes a transaction only when the sequencer is idle and the
  // result register is free or being emptied in the same cycle.
  assign item.ready = (state == S_IDLE) && (!res_valid || result.ready);
  assign accept     = item.valid && item.ready;
  assign start_acc  = accept && (item.mode == MODE_START);
  assign row_acc    = accept && (item.mode == MODE_ROW);
  assign row_hit    = row_acc && span_active;

  // A texture height of zero acts as one, and anything above 4096 saturates.
  always_comb begin
    if (texture_height == '0) begin
      h_eff = TEX_H_W'(1);
    end else if (texture_height > TEX_H_MAX) begin
      h_eff = TEX_H_MAX;
    end else begin
      h_eff = texture_height;
    end
  end

  // Strip geometry for a start transaction.
  always_comb begin
    s_eff    = (item.strip_height == '0) ? STRIP_W'(1) : item.strip_height;
    s_half   = SW1'(s_eff[STRIP_W-1:1]);
    top_wide = HALF_H - s_half;
    bot_wide = HALF_H + s_half;
    top_row  = (s_half >= HALF_H) ? '0 : top_wide[ROW_W-1:0];
    bot_row  = (bot_wide >= FULL_H) ? ROW_MAX : bot_wide[ROW_W-1:0];
    taller   = SW1'(s_eff) > FULL_H;
    off_wide = SW1'(s_eff) - FULL_H;
    offset   = off_wide[OFF_W:1];
    col_sat  = (12'(item.column) > COL_MAX) ? COL_MAX[COL_W-1:0] : item.column;
  end

  // Row pixel: texture y is the integer part of the position, clamped to the
  // current texture height; the position advances with a saturating add.
  always_comb begin
    ty_wide  = tex_position >> FRAC_BITS;
    tex_y    = (ty_wide >= POS_W'(h_eff)) ? TEX_W'(h_eff - TEX_H_W'(1)) : ty_wide[TEX_W-1:0];
    is_last  = current_row >= bottom_row;
    pos_sum  = {1'b0, tex_position} + {1'b0, tex_step};
    pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
  end

  // Sequencer for the shared arithmetic unit.
  always_comb begin
    ctl        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (start_acc) begin
          ctl.load   = 1'b1;
          state_next = S_DIV;
          cnt_next   = '0;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = use_offset ? S_MUL : S_FIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  wcts_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk        (clk),
    .ctl        (ctl),
    .tex_height (h_eff),
    .divisor_in (s_eff),
    .offset_in  (offset),
    .step       (div_step_val),
    .product    (mul_product)
  );

  // Control and strip state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      texture_height <= TEX_H_RESET;
      tex_position   <= '0;
      tex_step       <= '0;
      current_row    <= '0;
      bottom_row     <= '0;
      span_active    <= 1'b0;
      strip_column   <= '0;
      strip_tex_x    <= '0;
      use_offset     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_write) begin
        texture_height <= cfg_data;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (start_acc) begin
        strip_column <= col_sat;
        strip_tex_x  <= item.tex_column;
        current_row  <= top_row;
        bottom_row   <= bot_row;
        use_offset   <= taller;
        span_active  <= 1'b1;
      end
      if (row_hit) begin
        tex_position <= pos_next;
        if (is_last) begin
          span_active <= 1'b0;
        end else begin
          current_row <= current_row + ROW_W'(1);
        end
      end
      // The divide and, when needed, the multiply have finished.
      if (state == S_FIN) begin
        tex_step     <= div_step_val;
        tex_position <= use_offset ? mul_product : '0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (row_hit) begin
        res_pixel_valid <= 1'b1;
        res_column      <= strip_column;
        res_row         <= ROW_OUT_W'(current_row);
        res_tex_x       <= strip_tex_x;
        res_tex_y       <= tex_y;
        res_last        <= is_last;
      end else begin
        res_pixel_valid <= 1'b0;
        res_column      <= '0;
        res_row         <= '0;
        res_tex_x       <= '0;
        res_tex_y       <= '0;
        res_last        <= 1'b0;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.pixel_valid = res_pixel_valid;
  assign result.out_column  = res_column;
  assign result.out_row     = res_row;
  assign result.out_tex_x   = res_tex_x;
  assign result.out_tex_y   = res_tex_y;
  assign result.last_row    = res_last;

  // A start keeps the block busy while the step is computed.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> !item.ready)
    else $error("block ready right after a start transaction");

  // The bottom row of a strip ends it.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (row_hit && is_last) |=> !span_active)
    else $error("strip still active after its last row");

  // Rows never run past the bottom of an active strip.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    span_active |-> (current_row <= bottom_row))
    else $error("current row beyond bottom row");

  // The sequencer leaves the finish state straight back to idle.
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule
